// ===== sv/ptns_pkg.sv =====
`default_nettype none
package ptns_pkg;
    localparam int TABLE_DEPTH = 32;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_NBRS = 31;
    localparam logic [22:0] RADIUS_RESET = 23'd2573;
    localparam logic [22:0] MERGE_RESET = 23'd26;
    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_MERGE = 1'b1;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic [7:0] id;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_SCAN,
        ST_CLOSE
    } state_t;

    // per-cell control
    typedef struct packed {
        logic load;      // write new report or write-back entry into this cell
        logic shift;     // take neighbor's entry (ring rotate)
    } cell_ctl_t;
endpackage
`default_nettype wire

// ===== sv/ptns_cell.sv =====
`default_nettype none
module ptns_cell (
    input  wire logic             clk,
    input  wire ptns_pkg::cell_ctl_t ctl,
    input  wire ptns_pkg::entry_t new_entry,
    input  wire ptns_pkg::entry_t prev_entry,
    output      ptns_pkg::entry_t entry
);
    import ptns_pkg::*;
    entry_t data_reg;
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            data_reg <= new_entry;
        end
        else if (ctl.shift)
        begin
            data_reg <= prev_entry;
        end
    end
    assign entry = data_reg;
endmodule
`default_nettype wire

// ===== sv/ptns_dist.sv =====
`default_nettype none
// Squared distance: square each axis (registered), then sum combinationally.
module ptns_dist (
    input  wire logic        clk,
    input  wire ptns_pkg::entry_t a,
    input  wire ptns_pkg::entry_t b,
    output      logic [50:0] dist2
);
    import ptns_pkg::*;
    logic signed [24:0] dx, dy, dz;
    logic [24:0] mx, my, mz;
    logic [49:0] sx_reg, sy_reg, sz_reg;
    assign dx = 25'(a.x) - 25'(b.x);
    assign dy = 25'(a.y) - 25'(b.y);
    assign dz = 25'(a.z) - 25'(b.z);
    assign mx = dx[24] ? 25'(-dx) : 25'(dx);
    assign my = dy[24] ? 25'(-dy) : 25'(dy);
    assign mz = dz[24] ? 25'(-dz) : 25'(dz);
    always_ff @(posedge clk)
    begin
        sx_reg <= mx * mx;
        sy_reg <= my * my;
        sz_reg <= mz * mz;
    end
    assign dist2 = 51'(sx_reg) + 51'(sy_reg) + 51'(sz_reg);
endmodule
`default_nettype wire

// ===== sv/proximity_table_neighbor_search.sv =====
`default_nettype none
// Busy stays high while a report runs: the merge pass, the neighbor scan and the closing
// beat, which ends the run.
// Throughput: one report at a time; a new start is taken only while busy is low. The table
// is a ring of cells rotated past one distance unit, with a launch and a decide phase per
// entry, in the merge search and in the neighbor scan. The receiver cannot stall result beats.
// Reset (async, active low) empties the table and restores register defaults; cells keep data.
module proximity_table_neighbor_search (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic signed [23:0] pos_x,
    input  wire logic signed [23:0] pos_y,
    input  wire logic signed [23:0] pos_z,
    input  wire logic signed [15:0] vel_x,
    input  wire logic signed [15:0] vel_y,
    input  wire logic signed [15:0] vel_z,
    input  wire logic [7:0]  agent_id,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [22:0] cfg_data,
    output      logic        result_valid,
    output      logic        is_neighbor,
    output      logic [7:0]  nbr_id,
    output      logic signed [23:0] nbr_x,
    output      logic signed [23:0] nbr_y,
    output      logic signed [23:0] nbr_z,
    output      logic signed [15:0] nbr_vx,
    output      logic signed [15:0] nbr_vy,
    output      logic signed [15:0] nbr_vz,
    output      logic [4:0]  nbr_count,
    output      logic        last
);
    import ptns_pkg::*;
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // The table is a ring: cell i takes cell i+1, and the tail cell takes the
    // head (cell 0) or, when an entry is being dropped, holds a hole that is
    // later overwritten. Rotating count cells brings the table back in order,
    // with the head always in cell 0 feeding the distance unit.
    //
    // Merge pass: rotate once per entry; the first matching entry is not
    // written back, the tail moves down by one and the pass rotates the
    // remaining entries so the table ends in order again.

    state_t state_reg, state_next;
    logic [22:0] radius_reg, merge_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] step_reg, step_next;   // entries fed into distance unit
    logic merged_reg, merged_next;
    logic [4:0] found_reg, found_next;
    entry_t new_reg;
    logic [45:0] mt2_reg, nr2_reg;
    entry_t head_d1_reg;                       // entry matching pipelined distance

    entry_t cells [TABLE_DEPTH];
    cell_ctl_t ctl [TABLE_DEPTH];
    entry_t wb_entry;          // entry written to the tail of the ring
    logic [IDX_W-1:0] tail_idx;
    logic rotate, wb_en, load_new;
    logic [50:0] dist2;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            entry_t nb;
            if (g == TABLE_DEPTH - 1)
            begin : g_top
                assign nb = cells[0];
            end
            else
            begin : g_mid
                assign nb = cells[g + 1];
            end
            // rotation shifts every cell below the tail; tail gets write-back or the new report
            always_comb
            begin
                ctl[g].shift = rotate && (IDX_W'(g) < tail_idx);
                ctl[g].load  = (wb_en || load_new) && (IDX_W'(g) == tail_idx);
            end
            ptns_cell u_cell (
                .clk        (clk),
                .ctl        (ctl[g]),
                .new_entry  (wb_entry),
                .prev_entry (nb),
                .entry      (cells[g])
            );
        end
    endgenerate

    ptns_dist u_dist (
        .clk   (clk),
        .a     (cells[0]),
        .b     (new_reg),
        .dist2 (dist2)
    );

    assign busy = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !start;

    // Rotation model: in a pass over the current cnt entries, each step
    // moves cell0 out; cells 1..tail shift down; the popped entry is
    // written to the tail (cnt-1) unless dropped. Distances are registered,
    // so each step has two phases: phase 0 launches the head into
    // the distance unit, phase 1 decides on it (head_d1) and rotates.
    logic phase_reg, phase_next;
    logic hit_merge, hit_nbr;
    assign hit_merge = (46'(dist2) < mt2_reg) && (dist2[50:46] == '0);
    assign hit_nbr = (dist2 != '0) && (dist2[50:46] == '0) && (46'(dist2) <= nr2_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        step_next = step_reg;
        merged_next = merged_reg;
        found_next = found_reg;
        phase_next = phase_reg;
        rotate = 1'b0;
        wb_en = 1'b0;
        load_new = 1'b0;
        wb_entry = head_d1_reg;
        tail_idx = IDX_W'(cnt_reg - 1'b1);
        result_valid = 1'b0;
        is_neighbor = 1'b0;
        nbr_id = '0;
        nbr_x = '0;
        nbr_y = '0;
        nbr_z = '0;
        nbr_vx = '0;
        nbr_vy = '0;
        nbr_vz = '0;
        nbr_count = '0;
        last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MERGE;
                    step_next = '0;
                    merged_next = 1'b0;
                    found_next = '0;
                    phase_next = 1'b0;
                end
            end
            ST_MERGE:
            begin
                // phase 0: distance of head in flight; phase 1: decide, rotate
                if (step_reg == cnt_reg)
                begin
                    // append the new report at the tail
                    wb_entry = new_reg;
                    if (!merged_reg && cnt_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        // drop oldest: head is cell0; rotate it out, overwrite tail
                        rotate = 1'b1;
                        load_new = 1'b1;
                        tail_idx = IDX_W'(TABLE_DEPTH - 1);
                    end
                    else
                    begin
                        load_new = 1'b1;
                        tail_idx = IDX_W'(cnt_reg);
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = ST_SCAN;
                    step_next = '0;
                    phase_next = 1'b0;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    rotate = 1'b1;
                    if (!merged_reg && hit_merge)
                    begin
                        // drop head: shift remaining down, shrink
                        merged_next = 1'b1;
                        cnt_next = cnt_reg - 1'b1;
                        tail_idx = IDX_W'(cnt_reg - 1'b1);
                        step_next = step_reg;
                        // remaining entries to rotate: cnt-1-step, so the
                        // step count equals the new cnt when the pass ends
                    end
                    else
                    begin
                        wb_en = 1'b1;
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (step_reg == cnt_reg)
                begin
                    state_next = ST_CLOSE;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    rotate = 1'b1;
                    wb_en = 1'b1;
                    step_next = step_reg + 1'b1;
                    if (hit_nbr && found_reg < 5'(MAX_NBRS))
                    begin
                        result_valid = 1'b1;
                        is_neighbor = 1'b1;
                        nbr_id = head_d1_reg.id;
                        nbr_x = head_d1_reg.x;
                        nbr_y = head_d1_reg.y;
                        nbr_z = head_d1_reg.z;
                        nbr_vx = head_d1_reg.vx;
                        nbr_vy = head_d1_reg.vy;
                        nbr_vz = head_d1_reg.vz;
                        found_next = found_reg + 1'b1;
                    end
                end
            end
            ST_CLOSE:
            begin
                result_valid = 1'b1;
                last = 1'b1;
                nbr_count = found_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            step_reg <= '0;
            merged_reg <= 1'b0;
            found_reg <= '0;
            phase_reg <= 1'b0;
            radius_reg <= RADIUS_RESET;
            merge_reg <= MERGE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            step_reg <= step_next;
            merged_reg <= merged_next;
            found_reg <= found_next;
            phase_reg <= phase_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == {7'd0, CFG_RADIUS})
                begin
                    radius_reg <= cfg_data;
                end
                else if (cfg_index == {7'd0, CFG_MERGE})
                begin
                    merge_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_d1_reg <= cells[0];
        mt2_reg <= merge_reg * merge_reg;
        nr2_reg <= radius_reg * radius_reg;
        if (start && !busy)
        begin
            new_reg <= '{x: pos_x, y: pos_y, z: pos_z, vx: vel_x, vy: vel_y,
                         vz: vel_z, id: agent_id};
        end
    end
endmodule
`default_nettype wire
